FILE: rtl/lkvc_pkg.sv
// Shared types and codes for the LRU key-value cache.
package lkvc_pkg;

   // Request word: one get or put.
   typedef struct packed {
      logic               action;
      logic signed [31:0] lookup_key;
      logic signed [31:0] store_value;
   } req_word_type;

   // Response word: result of one get.
   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
   } rsp_word_type;

   // Action codes.
   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // Which cell an update targets.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_TOUCH_HIT,
      OP_REPLACE_LRU,
      OP_FILL_FREE
   } cell_op_type;

   // Update command broadcast to every cell.
   typedef struct packed {
      cell_op_type        op;
      logic               write_key;
      logic               write_value;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } cell_cmd_type;

   // Data handed from one cell to the next.
   typedef struct packed {
      logic               free_seen;
      logic               hit;
      logic signed [31:0] hit_value;
   } chain_type;

endpackage

FILE: rtl/lkvc_cell.sv
// One cache entry: key, value, valid bit and recency rank.
module lkvc_cell #(
   parameter int RANK_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmp_en,
   input  logic signed [31:0]     cmp_key,
   input  lkvc_pkg::cell_cmd_type cmd,
   input  logic [RANK_W-1:0]      ref_rank,
   input  lkvc_pkg::chain_type    chain_in,
   input  logic [RANK_W-1:0]      hit_rank_in,
   output lkvc_pkg::chain_type    chain_out,
   output logic [RANK_W-1:0]      hit_rank_out
);

   logic signed [31:0] key_ff,   key_in;
   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               match_ff, match_in;
   logic [RANK_W-1:0]  rank_ff,  rank_in;
   logic               mine;
   logic               target;

   assign mine = valid_ff && match_ff;

   // Pass hit data and first-free token down the row
   always_comb begin
      chain_out.free_seen = chain_in.free_seen | ~valid_ff;
      chain_out.hit       = chain_in.hit | mine;
      chain_out.hit_value = chain_in.hit_value | (mine ? value_ff : 32'sd0);
      hit_rank_out        = hit_rank_in | (mine ? rank_ff : '0);
   end

   // Is this cell the one being written
   always_comb begin
      unique case (cmd.op)
         lkvc_pkg::OP_TOUCH_HIT:   target = mine;
         lkvc_pkg::OP_REPLACE_LRU: target = valid_ff && (rank_ff == ref_rank);
         lkvc_pkg::OP_FILL_FREE:   target = !valid_ff && !chain_in.free_seen;
         default:                  target = 1'b0;
      endcase
   end

   // Next state of the entry
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      match_in = match_ff;
      if (cmp_en) begin
         match_in = (key_ff == cmp_key);
      end
      if (target) begin
         valid_in = 1'b1;
         rank_in  = '0;
         if (cmd.write_key) begin
            key_in = cmd.key;
         end
         if (cmd.write_value) begin
            value_in = cmd.value;
         end
      end else if (cmd.op != lkvc_pkg::OP_NONE && valid_ff && rank_ff < ref_rank) begin
         // younger entries age by one
         rank_in = rank_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         match_ff <= match_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

FILE: rtl/lru_key_value_cache.sv
// LRU key-value cache: a row of entry cells under a two-state sequencer.
// Each word has two steps: accept (keys compared in every cell) and update
// (hit, LRU and first-free found along the cell row, ranks updated).
// No new word is taken until update is done. A get's response is registered
// when update ends, held until taken; a later get waits in update while held.
// Synchronous reset empties the cache and sets capacity to 16.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lkvc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lkvc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_en,
   input  logic [4:0]             csr_write_data
);

   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   lkvc_pkg::state_type    state_ff, state_in;
   lkvc_pkg::req_word_type req_ff, req_in;
   lkvc_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [4:0]             capacity_ff, capacity_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   accept;
   logic                   go;
   logic [8:0]             cap_wide;
   logic [CNT_W-1:0]       eff_cap;
   logic                   full;
   lkvc_pkg::cell_cmd_type cmd;
   logic [RANK_W-1:0]      ref_rank;

   lkvc_pkg::chain_type    chain [0:MAX_ENTRIES];
   logic [RANK_W-1:0]      hit_rank [0:MAX_ENTRIES];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != lkvc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign chain[0]    = '0;
   assign hit_rank[0] = '0;

   // Row of entry cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lkvc_cell #(.RANK_W(RANK_W)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmp_en       (accept),
         .cmp_key      (req_word.lookup_key),
         .cmd          (cmd),
         .ref_rank     (ref_rank),
         .chain_in     (chain[i]),
         .hit_rank_in  (hit_rank[i]),
         .chain_out    (chain[i+1]),
         .hit_rank_out (hit_rank[i+1])
      );
   end

   // Effective capacity, clamped to 1..MAX_ENTRIES
   always_comb begin
      cap_wide = {4'd0, capacity_ff};
      if (cap_wide == 9'd0) begin
         cap_wide = 9'd1;
      end else if (cap_wide > 9'(MAX_ENTRIES)) begin
         cap_wide = 9'(MAX_ENTRIES);
      end
      eff_cap = cap_wide[CNT_W-1:0];
      full    = (count_ff >= eff_cap);
   end

   // Sequencer: next state, cell command and response
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in     = count_ff;
      capacity_in  = csr_write_en ? csr_write_data : capacity_ff;
      go           = 1'b0;
      cmd.op          = lkvc_pkg::OP_NONE;
      cmd.write_key   = 1'b0;
      cmd.write_value = 1'b0;
      cmd.key         = req_ff.lookup_key;
      cmd.value       = req_ff.store_value;
      ref_rank        = '0;

      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (accept) begin
               req_in   = req_word;
               state_in = lkvc_pkg::ST_UPDATE;
            end
         end
         lkvc_pkg::ST_UPDATE: begin
            go = (req_ff.action == lkvc_pkg::ACT_PUT) || !rsp_valid_ff || !rsp_stall;
            if (go) begin
               state_in = lkvc_pkg::ST_IDLE;
               if (chain[MAX_ENTRIES].hit) begin
                  cmd.op          = lkvc_pkg::OP_TOUCH_HIT;
                  cmd.write_value = (req_ff.action == lkvc_pkg::ACT_PUT);
                  ref_rank        = hit_rank[MAX_ENTRIES];
               end else if (req_ff.action == lkvc_pkg::ACT_PUT) begin
                  cmd.write_key   = 1'b1;
                  cmd.write_value = 1'b1;
                  if (full) begin
                     cmd.op   = lkvc_pkg::OP_REPLACE_LRU;
                     ref_rank = RANK_W'(count_ff - 1'b1);
                  end else begin
                     cmd.op   = lkvc_pkg::OP_FILL_FREE;
                     ref_rank = RANK_W'(count_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               if (req_ff.action == lkvc_pkg::ACT_GET) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.hit        = chain[MAX_ENTRIES].hit;
                  rsp_in.read_value = chain[MAX_ENTRIES].hit_value;
               end
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         capacity_ff  <= 5'd16;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: test/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;

   localparam int CACHE_DEPTH  = 16;
   localparam int KEY_POOL     = 24;
   localparam int DRAIN_CYCLES = 4;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   lkvc_pkg::req_word_type req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   lkvc_pkg::rsp_word_type rsp_word;
   logic                   csr_write_en;
   logic [4:0]             csr_write_data;

   // Mirror of the cache contents, updated as each word is accepted.
   logic signed [31:0] mirror_key[CACHE_DEPTH];
   logic signed [31:0] mirror_value[CACHE_DEPTH];
   bit                 mirror_used[CACHE_DEPTH];
   int unsigned        mirror_rank[CACHE_DEPTH];
   int unsigned        entry_total = 0;
   bit [4:0]           capacity_reg = 5'd16;

   // Get results still owed by the block, oldest first.
   lkvc_pkg::rsp_word_type pending_get_results[$];

   logic [31:0] key_pool[KEY_POOL];
   bit          idling_on = 1'b1;
   int          failures = 0;
   int          words_sent = 0;
   int          gets_seen = 0;
   int          hits_seen = 0;
   int          evictions = 0;
   int          capacity_writes = 0;

   lru_key_value_cache #(
      .MAX_ENTRIES(CACHE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Moves an entry to the front; entries that were ahead of it age by one.
   function automatic void touch_entry(input int slot);
      int unsigned old_rank;
      old_rank = mirror_rank[slot];
      for (int i = 0; i < CACHE_DEPTH; i++)
         if (mirror_used[i] && i != slot && mirror_rank[i] < old_rank) mirror_rank[i]++;
      mirror_rank[slot] = 0;
   endfunction

   // Applies one accepted word to the mirror and returns the get result, if any.
   function automatic void predict_access(input lkvc_pkg::req_word_type w,
                                          output bit gives_rsp,
                                          output lkvc_pkg::rsp_word_type result);
      int          slot;
      int          victim;
      int unsigned limit;
      slot = -1;
      victim = -1;
      result = '0;
      gives_rsp = 1'b0;
      for (int i = 0; i < CACHE_DEPTH; i++)
         if (slot < 0 && mirror_used[i] && mirror_key[i] == w.lookup_key) slot = i;

      if (w.action == lkvc_pkg::ACT_GET) begin
         gives_rsp = 1'b1;
         gets_seen++;
         if (slot >= 0) begin
            result.hit = 1'b1;
            result.read_value = mirror_value[slot];
            touch_entry(slot);
            hits_seen++;
         end
         return;
      end

      // Put of a new key: evict the oldest when full, else fill the first hole.
      if (slot < 0) begin
         limit = (capacity_reg == 0) ? 1 :
                 (capacity_reg > CACHE_DEPTH) ? CACHE_DEPTH : capacity_reg;
         if (entry_total >= limit) begin
            for (int i = 0; i < CACHE_DEPTH; i++)
               if (mirror_used[i] && (victim < 0 || mirror_rank[i] > mirror_rank[victim]))
                  victim = i;
            slot = victim;
            evictions++;
         end else begin
            for (int i = 0; i < CACHE_DEPTH; i++)
               if (slot < 0 && !mirror_used[i]) slot = i;
            mirror_used[slot] = 1'b1;
            mirror_rank[slot] = entry_total;
            entry_total++;
         end
         mirror_key[slot] = w.lookup_key;
      end
      mirror_value[slot] = w.store_value;
      touch_entry(slot);
   endfunction

   // Presents one word and holds it until the block takes it.
   task automatic send_word(input logic action, input logic [31:0] key,
                            input logic [31:0] value);
      lkvc_pkg::req_word_type w;
      bit                     gives_rsp;
      lkvc_pkg::rsp_word_type result;
      w.action = action;
      w.lookup_key = key;
      w.store_value = value;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_access(w, gives_rsp, result);
      if (gives_rsp) pending_get_results.push_back(result);
      words_sent++;
   endtask

   // Random gap on the request side.
   task automatic maybe_pause();
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drops valid, waits for every owed result, then lets the last put settle.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_get_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [4:0] value);
      wait_for_drain();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      capacity_reg = value;
      capacity_writes++;
   endtask

   // Empty cache, extreme keys and values, hits, misses and an update.
   task automatic test_empty_and_extremes();
      send_word(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      maybe_pause();
      send_word(lkvc_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(lkvc_pkg::ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(lkvc_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(lkvc_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
      maybe_pause();
      send_word(lkvc_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h5555_5555);
      send_word(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'hAAAA_AAAA);
      send_word(lkvc_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h1234_5678);
      send_word(lkvc_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
   endtask

   // Capacity dropped under the entry count: new keys replace the oldest.
   task automatic test_capacity_below_count();
      set_capacity(5'd2);
      send_word(lkvc_pkg::ACT_PUT, 32'd5, 32'd55);
      send_word(lkvc_pkg::ACT_GET, 32'h7FFF_FFFF, 32'd0);
      maybe_pause();
      send_word(lkvc_pkg::ACT_GET, 32'd5, 32'd0);
   endtask

   // Zero acts as one entry, values above the depth act as the full depth.
   task automatic test_capacity_clamp();
      set_capacity(5'd0);
      send_word(lkvc_pkg::ACT_PUT, 32'd7, 32'hDEAD_BEEF);
      send_word(lkvc_pkg::ACT_GET, 32'd7, 32'd0);
      send_word(lkvc_pkg::ACT_GET, 32'd0, 32'd0);
      set_capacity(5'd31);
      send_word(lkvc_pkg::ACT_PUT, 32'd9, 32'hCAFE_F00D);
      send_word(lkvc_pkg::ACT_GET, 32'd9, 32'd0);
   endtask

   // Mixed gets and puts over a key set sized to give both hits and evictions.
   task automatic run_random_traffic(input logic [4:0] capacity, input int words,
                                     input int key_span);
      logic [31:0] key;
      set_capacity(capacity);
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(0, 9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(0, key_span - 1)];
         send_word($urandom_range(0, 1) ? lkvc_pkg::ACT_PUT : lkvc_pkg::ACT_GET,
                   key, $urandom);
         maybe_pause();
      end
   endtask

   // Response side stall bursts.
   initial begin : rsp_stall_gen
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every taken response word with the oldest owed result.
   always @(posedge clock) begin : check_rsp
      lkvc_pkg::rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_get_results.size() == 0) begin
            $error("unexpected response word: hit=%0b read_value=%0d",
                   rsp_word.hit, rsp_word.read_value);
            failures++;
         end else begin
            want = pending_get_results.pop_front();
            if (rsp_word.hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_word.hit);
               failures++;
            end
            if (rsp_word.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d",
                      want.read_value, rsp_word.read_value);
               failures++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;

      // Extremes first, then random keys; a small window gives repeat hits.
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      test_capacity_below_count();
      test_capacity_clamp();

      run_random_traffic(5'd16, 80, 20);
      run_random_traffic(5'd1, 40, 3);
      run_random_traffic(5'd4, 70, 7);
      run_random_traffic(5'd31, 80, 20);
      run_random_traffic(5'd17, 50, 20);
      run_random_traffic(5'd2, 50, 4);
      run_random_traffic(5'd0, 40, 3);
      run_random_traffic(5'd8, 60, 12);
      idling_on = 1'b0;
      run_random_traffic(5'd16, 80, KEY_POOL);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d words: %0d gets (%0d hits), %0d evictions, %0d capacity writes.",
               words_sent, gets_seen, hits_seen, evictions, capacity_writes);
      $display("Request gaps and response stalls were random except in the closing phase.");
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache.sv
test/tb_lru_key_value_cache.sv
